// ----- hdl/asc_pkg.sv -----
// Shared types and constants for the aspect scaler with scanlines.
// Holds the input and result item structs, status codes and register indexes.
// No dependencies.
package asc_pkg;

  localparam int MAX_SRC_WIDTH_DEF   = 1024;
  localparam int MAX_SRC_HEIGHT_DEF  = 256;
  localparam int SCALE_FRAC_BITS_DEF = 12;

  localparam int POS_X_W = 15;
  localparam int POS_Y_W = 14;
  localparam int SCALE_W = 14;
  localparam int SRC_W_W = 11;
  localparam int SRC_H_W = 9;
  localparam int INTEN_W = 9;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_W     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_ON   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY = 3'd5;

  localparam logic [1:0] MODE_V3 = 2'd0;
  localparam logic [1:0] MODE_V6 = 2'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] ST_PIXEL   = 2'd0;
  localparam logic [1:0] ST_WRITE   = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic [7:0]         in_red;
    logic [7:0]         in_green;
    logic [7:0]         in_blue;
    logic [7:0]         in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } out_item_t;

endpackage

// ----- hdl/asc_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module asc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/asc_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// Quotient is valid only when numer < denom * 2^QW. No dependencies.
module asc_div_pipe #(
  parameter int NW = 27,
  parameter int DW = 17,
  parameter int QW = 10
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] numer,
  input  logic [DW-1:0] denom,
  output logic [QW-1:0] quot
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem [1:QW];
  logic [DW-1:0] dv  [1:QW];
  logic [QW-1:0] qt  [1:QW];

  for (genvar i = 1; i <= QW; i++) begin : g_stage
    logic [NW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [CW-1:0] trial;
    logic [CW-1:0] r_ext;

    if (i == 1) begin : g_first
      assign r_in = numer;
      assign d_in = denom;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[i-1];
      assign d_in = dv[i-1];
      assign q_in = qt[i-1];
    end

    assign trial = CW'(d_in) << (QW - i);
    assign r_ext = CW'(r_in);

    always_ff @(posedge clk) begin
      if (en) begin
        dv[i] <= d_in;
        if (r_ext >= trial) begin
          rem[i] <= NW'(r_ext - trial);
          qt[i]  <= q_in | (QW'(1) << (QW - i));
        end else begin
          rem[i] <= r_in;
          qt[i]  <= q_in;
        end
      end
    end
  end

  assign quot = qt[QW];

endmodule

// ----- hdl/aspect_scaler_with_scanlines.sv -----
// Nearest-neighbor aspect scaler with scanline darkening.
// Stages: capture, the one-bit-per-stage divider pipeline, frame RAM read and output.
// Throughput: one item per cycle; the whole pipeline holds while the output is stalled.
// Reset (rst, synchronous): clears valid bits and loads register defaults; frame RAM
// content is not cleared.
module aspect_scaler_with_scanlines
  import asc_pkg::*;
#(
  parameter int MAX_SRC_WIDTH   = MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT  = MAX_SRC_HEIGHT_DEF,
  parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FB  = SCALE_FRAC_BITS;
  localparam int DHW = SCALE_W + 3;
  localparam int DVW = SCALE_W + 4;
  localparam int QX  = $clog2(MAX_SRC_WIDTH);
  localparam int QY  = $clog2(MAX_SRC_HEIGHT);
  localparam int QW  = (QX > QY) ? QX : QY;
  localparam int SWW = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SHW = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int PXW = SWW + DHW;
  localparam int PYW = SHW + DVW;
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW  = $clog2(DEPTH);

  typedef struct packed {
    logic               opcode;
    logic               wr_ok;
    logic               in_rng;
    logic               dark_en;
    logic [8:0]         dark;
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic [31:0]        rgba;
  } meta_t;

  // configuration registers
  logic [1:0]         mode_select;
  logic [SCALE_W-1:0] scale_factor;
  logic [SRC_W_W-1:0] source_width;
  logic [SRC_H_W-1:0] source_height;
  logic               scanlines_on;
  logic [INTEN_W-1:0] scanline_intensity;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_select        <= MODE_V6;
      scale_factor       <= SCALE_W'(4096);
      source_width       <= SRC_W_W'(320);
      source_height      <= SRC_H_W'(200);
      scanlines_on       <= 1'b0;
      scanline_intensity <= INTEN_W'(128);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:      mode_select        <= cfg_data[1:0];
        REG_SCALE:     scale_factor       <= cfg_data[SCALE_W-1:0];
        REG_SRC_W:     source_width       <= cfg_data[SRC_W_W-1:0];
        REG_SRC_H:     source_height      <= cfg_data[SRC_H_W-1:0];
        REG_SCAN_ON:   scanlines_on       <= cfg_data[0];
        REG_INTENSITY: scanline_intensity <= cfg_data[INTEN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output register is free or being taken
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // capture stage: denominators, clamped sizes, darkening factor
  logic [DHW-1:0] den_h;
  logic [DVW-1:0] den_v;
  logic [SWW-1:0] sw_c;
  logic [SHW-1:0] sh_c;
  logic [8:0]     dark_c;

  always_comb begin
    den_h = DHW'(scale_factor) * DHW'(5);
    case (mode_select)
      MODE_V3: den_v = DVW'(scale_factor) * DVW'(3);
      MODE_V6: den_v = DVW'(scale_factor) * DVW'(6);
      default: den_v = DVW'(scale_factor) * DVW'(12);
    endcase
    if (source_width > MAX_SRC_WIDTH) sw_c = SWW'(MAX_SRC_WIDTH);
    else                              sw_c = SWW'(source_width);
    if (source_height > MAX_SRC_HEIGHT) sh_c = SHW'(MAX_SRC_HEIGHT);
    else                                sh_c = SHW'(source_height);
    if (scanline_intensity > INTEN_W'(256)) dark_c = 9'd0;
    else                                    dark_c = 9'(10'd256 - 10'(scanline_intensity));
  end

  logic           s0_vld;
  in_item_t       s0_item;
  logic [DHW-1:0] s0_dh;
  logic [DVW-1:0] s0_dv;
  logic [SWW-1:0] s0_sw;
  logic [SHW-1:0] s0_sh;
  logic           s0_dark_en;
  logic [8:0]     s0_dark;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= in_valid;
    end
    if (adv) begin
      s0_item    <= in_data;
      s0_dh      <= den_h;
      s0_dv      <= den_v;
      s0_sw      <= sw_c;
      s0_sh      <= sh_c;
      s0_dark_en <= scanlines_on && in_data.pos_y[0];
      s0_dark    <= dark_c;
    end
  end

  // dividers: source index = (dst << FB) / denominator
  logic [QW-1:0] qx;
  logic [QW-1:0] qy;

  asc_div_pipe #(.NW(POS_X_W + FB), .DW(DHW), .QW(QW)) u_div_x (
    .clk   (clk),
    .en    (adv),
    .numer ({s0_item.pos_x, FB'(0)}),
    .denom (s0_dh),
    .quot  (qx)
  );

  asc_div_pipe #(.NW(POS_Y_W + FB), .DW(DVW), .QW(QW)) u_div_y (
    .clk   (clk),
    .en    (adv),
    .numer ({s0_item.pos_y, FB'(0)}),
    .denom (s0_dv),
    .quot  (qy)
  );

  // side pipeline alongside the dividers; destination size in stage 1, range in stage 2
  logic           v [1:QW];
  meta_t          m [1:QW];
  meta_t          m1_rng;
  logic [PXW-1:0] p1_dw;
  logic [PYW-1:0] p1_dh;

  always_comb begin
    m1_rng        = m[1];
    m1_rng.in_rng = (m[1].pos_x < (p1_dw >> FB)) && (m[1].pos_y < (p1_dh >> FB));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 1; j <= QW; j++) v[j] <= 1'b0;
    end else if (adv) begin
      v[1] <= s0_vld;
      for (int j = 2; j <= QW; j++) v[j] <= v[j-1];
    end
    if (adv) begin
      p1_dw <= PXW'(s0_sw) * PXW'(s0_dh);
      p1_dh <= PYW'(s0_sh) * PYW'(s0_dv);
      m[1].opcode  <= s0_item.opcode;
      m[1].wr_ok   <= (s0_item.pos_x < MAX_SRC_WIDTH) && (s0_item.pos_y < MAX_SRC_HEIGHT);
      m[1].in_rng  <= 1'b0;
      m[1].dark_en <= s0_dark_en;
      m[1].dark    <= s0_dark;
      m[1].pos_x   <= s0_item.pos_x;
      m[1].pos_y   <= s0_item.pos_y;
      m[1].rgba    <= {s0_item.in_alpha, s0_item.in_blue, s0_item.in_green, s0_item.in_red};
      m[2]         <= m1_rng;
      for (int j = 3; j <= QW; j++) m[j] <= m[j-1];
    end
  end

  // frame RAM stage: writes and reads happen in item order here
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [31:0]   rd_word;

  assign rd_addr = AW'(AW'(qy[QY-1:0]) * AW'(MAX_SRC_WIDTH)) + AW'(qx[QX-1:0]);
  assign wr_addr = AW'(AW'(m[QW].pos_y[QY-1:0]) * AW'(MAX_SRC_WIDTH))
                 + AW'(m[QW].pos_x[QX-1:0]);
  assign wr_en   = adv && v[QW] && (m[QW].opcode == OP_WRITE) && m[QW].wr_ok;

  asc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_frame (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (m[QW].rgba),
    .re    (adv),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  logic  r_vld;
  meta_t r_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else if (adv) begin
      r_vld <= v[QW];
    end
    if (adv) begin
      r_meta <= m[QW];
    end
  end

  // darken and format the result
  logic [16:0] pr;
  logic [16:0] pg;
  logic [16:0] pb;
  out_item_t   res;

  always_comb begin
    pr  = 17'(rd_word[7:0])   * 17'(r_meta.dark);
    pg  = 17'(rd_word[15:8])  * 17'(r_meta.dark);
    pb  = 17'(rd_word[23:16]) * 17'(r_meta.dark);
    res = '0;
    if (r_meta.opcode == OP_WRITE) begin
      res.status = ST_WRITE;
    end else if (!r_meta.in_rng) begin
      res.status = ST_OUTSIDE;
    end else begin
      res.status    = ST_PIXEL;
      res.out_alpha = rd_word[31:24];
      if (r_meta.dark_en && (rd_word[31:24] != 8'd0)) begin
        res.out_red   = pr[15:8];
        res.out_green = pg[15:8];
        res.out_blue  = pb[15:8];
      end else begin
        res.out_red   = rd_word[7:0];
        res.out_green = rd_word[15:8];
        res.out_blue  = rd_word[23:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= r_vld;
    end
    if (adv) begin
      out_data <= res;
    end
  end

  a_write_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_WRITE) |->
      (out_data.out_red == 8'd0) && (out_data.out_green == 8'd0) &&
      (out_data.out_blue == 8'd0) && (out_data.out_alpha == 8'd0))
    else $error("write result carries color");

  a_outside_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_OUTSIDE) |->
      (out_data.out_red == 8'd0) && (out_data.out_alpha == 8'd0))
    else $error("outside read carries color");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s0_vld)
    else $error("accepted item lost at capture");

  a_hold_output: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data) && $stable(r_vld))
    else $error("pipeline moved while output stalled");

endmodule

// ----- tb/tb_aspect_scaler_with_scanlines.sv -----
// Testbench for the aspect scaler with scanlines: random and directed pixel traffic.
// Scoreboard class predicts results from its own frame copy; depends on asc_pkg and the RTL.
module tb_aspect_scaler_with_scanlines;
  import asc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = MAX_SRC_WIDTH_DEF;
  localparam int MAXH = MAX_SRC_HEIGHT_DEF;
  localparam int FRAC = SCALE_FRAC_BITS_DEF;
  localparam int LIMIT = 400000;

  class pixel_scoreboard;
    logic [31:0] frame [int];
    out_item_t pending [$];
    int errors;
    logic [1:0] mode;
    logic [13:0] scale;
    logic [10:0] src_w;
    logic [8:0] src_h;
    logic scan_on;
    logic [8:0] inten;

    function void set_defaults();
      mode = MODE_V6; scale = 14'd4096; src_w = 11'd320; src_h = 9'd200;
      scan_on = 1'b0; inten = 9'd128; errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_MODE:      mode = v[1:0];
        REG_SCALE:     scale = v[13:0];
        REG_SRC_W:     src_w = v[10:0];
        REG_SRC_H:     src_h = v[8:0];
        REG_SCAN_ON:   scan_on = v[0];
        REG_INTENSITY: inten = v[8:0];
        default: ;
      endcase
    endfunction

    function longint vbase();
      if (mode == MODE_V3) return 3;
      if (mode == MODE_V6) return 6;
      return 12;
    endfunction

    function longint dst_size(longint sz, longint lim, longint base);
      if (sz > lim) sz = lim;
      return (sz * base * scale) >>> FRAC;
    endfunction

    function bit map_pos(longint d, longint sz, longint lim, longint base, output longint s);
      longint den;
      if (sz > lim) sz = lim;
      den = base * scale;
      s = 0;
      if (den == 0 || d >= ((sz * den) >>> FRAC)) return 0;
      s = (d <<< FRAC) / den;
      if (s >= sz) s = sz - 1;
      return 1;
    endfunction

    // Both axes must map for a read to hit a stored pixel.
    function bit read_hits(longint x, longint y, output longint sx, output longint sy);
      bit hx, hy;
      hx = map_pos(x, src_w, MAXW, 5, sx);
      hy = map_pos(y, src_h, MAXH, vbase(), sy);
      return hx && hy;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      longint sx, sy, dk;
      logic [31:0] w;
      r = '0;
      if (it.opcode == OP_WRITE) begin
        if (it.pos_x < MAXW && it.pos_y < MAXH)
          frame[it.pos_y * MAXW + it.pos_x] = {it.in_alpha, it.in_blue, it.in_green, it.in_red};
        r.status = ST_WRITE;
      end else if (!read_hits(it.pos_x, it.pos_y, sx, sy)) begin
        r.status = ST_OUTSIDE;
      end else begin
        w = frame.exists(sy * MAXW + sx) ? frame[sy * MAXW + sx] : 32'd0;
        r.status = ST_PIXEL;
        r.out_red = w[7:0]; r.out_green = w[15:8]; r.out_blue = w[23:16];
        r.out_alpha = w[31:24];
        if (scan_on && it.pos_y[0] && w[31:24] != 0) begin
          dk = 256 - (inten > 256 ? 256 : inten);
          r.out_red = 8'((w[7:0] * dk) >> 8);
          r.out_green = 8'((w[15:8] * dk) >> 8);
          r.out_blue = 8'((w[23:16] * dk) >> 8);
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result exp none act %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.out_red !== e.out_red ||
          got.out_green !== e.out_green || got.out_blue !== e.out_blue ||
          got.out_alpha !== e.out_alpha) begin
        $display("%0t result mismatch exp st=%0d rgba=%h_%h_%h_%h act st=%0d rgba=%h_%h_%h_%h",
          $time, e.status, e.out_red, e.out_green, e.out_blue, e.out_alpha,
          got.status, got.out_red, got.out_green, got.out_blue, got.out_alpha);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0, cfg_valid = 0;
  in_item_t in_data = '0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_stall, out_valid, cfg_ready;
  out_item_t out_data;

  pixel_scoreboard sb;
  int send_idle = 0, recv_idle = 0;
  int hold_len = 0;
  int hold_off = 0;
  bit hold_taken = 0;
  int cycles = 0;
  bit written [int];

  always #5 clk = ~clk;

  aspect_scaler_with_scanlines uut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stall, or a long counted hold-off.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_len > 0 && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_off <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    if (it.opcode == OP_WRITE && it.pos_x < MAXW && it.pos_y < MAXH)
      written[it.pos_y * MAXW + it.pos_x] = 1;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic set_config(int md, int sc, int w, int h, int so, int it);
    drain();
    write_reg(REG_MODE, CFG_DATA_W'(md));
    write_reg(REG_SCALE, CFG_DATA_W'(sc));
    write_reg(REG_SRC_W, CFG_DATA_W'(w));
    write_reg(REG_SRC_H, CFG_DATA_W'(h));
    write_reg(REG_SCAN_ON, CFG_DATA_W'(so));
    write_reg(REG_INTENSITY, CFG_DATA_W'(it));
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t pix_write(int x, int y);
    in_item_t it;
    it = '0;
    it.opcode = OP_WRITE; it.pos_x = POS_X_W'(x); it.pos_y = POS_Y_W'(y);
    it.in_red = 8'($urandom); it.in_green = 8'($urandom); it.in_blue = 8'($urandom);
    it.in_alpha = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
    return it;
  endfunction

  // Read a destination pixel; out-of-range reads or mapped-to-written only.
  task automatic try_read(int x, int y);
    in_item_t it;
    longint sx, sy;
    it = '0;
    it.opcode = OP_READ; it.pos_x = POS_X_W'(x); it.pos_y = POS_Y_W'(y);
    it.in_red = 8'($urandom); it.in_green = 8'($urandom); it.in_blue = 8'($urandom);
    it.in_alpha = 8'($urandom);
    if (sb.read_hits(x, y, sx, sy) && !written.exists(int'(sy * MAXW + sx))) begin
      send_item(pix_write(int'(sx), int'(sy)));
    end
    send_item(it);
  endtask

  task automatic random_phase(int n, int ww, int hh);
    longint dw, dh;
    for (int i = 0; i < n; i++) begin
      dw = sb.dst_size(sb.src_w, MAXW, 5);
      dh = sb.dst_size(sb.src_h, MAXH, sb.vbase());
      case ($urandom_range(9))
        0, 1, 2: send_item(pix_write($urandom_range(ww - 1), $urandom_range(hh - 1)));
        3: send_item(pix_write($urandom_range(32767), $urandom_range(16383)));
        4: try_read($urandom_range(32767), $urandom_range(16383));
        default:
          try_read(dw > 0 ? $urandom_range(int'(dw - 1)) : 0,
                   dh > 0 ? $urandom_range(int'(dh - 1)) : 0);
      endcase
    end
  endtask

  initial begin
    in_item_t it;
    sb = new();
    sb.set_defaults();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 38; recv_idle = 86;
    // Directed: small source, every register at extremes.
    set_config(MODE_V3, 4096, 4, 4, 1, 256);
    for (int y = 0; y < 4; y++)
      for (int x = 0; x < 4; x++) send_item(pix_write(x, y));
    send_item(pix_write(1023, 255));
    send_item(pix_write(1024, 0));
    send_item(pix_write(32767, 16383));
    it = '1; it.opcode = OP_WRITE; it.pos_x = '0; it.pos_y = POS_Y_W'(300); send_item(it);
    try_read(0, 1);
    try_read(19, 11);
    try_read(20, 0);
    try_read(32767, 16383);
    set_config(3, 16383, 2047, 511, 1, 511);
    try_read(0, 1);
    try_read(5000, 3000);
    set_config(2, 1, 1, 1, 0, 0);
    try_read(0, 0);
    set_config(MODE_V6, 16383, 1, 1, 1, 0);
    try_read(0, 0); try_read(4, 5);
    // Random phases.
    set_config(MODE_V6, 4096, 32, 16, 1, 128);
    random_phase(380, 32, 16);
    send_idle = 86; recv_idle = 38;
    set_config(2, 2000, 1024, 256, 1, 300);
    random_phase(340, 1024, 256);
    send_idle = 0; recv_idle = 0;
    set_config(MODE_V3, 9000, 16, 8, 1, 64);
    hold_len = 200;
    random_phase(300, 16, 8);
    drain();
    set_config($urandom_range(3), $urandom_range(16383), $urandom_range(1, 40),
               $urandom_range(1, 20), 1, $urandom_range(256));
    random_phase(300, 40, 20);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ----- aspect_scaler_with_scanlines.f -----
hdl/asc_pkg.sv
hdl/asc_ram.sv
hdl/asc_div_pipe.sv
hdl/aspect_scaler_with_scanlines.sv
tb/tb_aspect_scaler_with_scanlines.sv
